FILE: src/rcm_pkg.sv
package rcm_pkg;

    localparam int CoordW = 15;
    localparam int DistW  = 10;
    localparam int LimW   = 5;

    typedef logic [CoordW-1:0] coord_t;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } box_t;

    typedef enum logic [1:0] {
        REG_MERGE_DISTANCE = 2'd0,
        REG_LIST_LIMIT     = 2'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLACE,
        ST_PASS,
        ST_EMIT
    } state_t;

    // Near test on 18-bit signed arithmetic.
    function automatic logic boxes_near(box_t p, box_t q, logic [DistW-1:0] d);
        logic signed [17:0] dd;
        dd = {8'd0, d};
        return ($signed({3'd0, p.x0}) - dd <= $signed({3'd0, q.x1})) &&
               ($signed({3'd0, p.x1}) + dd >= $signed({3'd0, q.x0})) &&
               ($signed({3'd0, p.y0}) - dd <= $signed({3'd0, q.y1})) &&
               ($signed({3'd0, p.y1}) + dd >= $signed({3'd0, q.y0}));
    endfunction

    function automatic box_t box_union(box_t p, box_t q);
        box_t r;
        r.x0 = (q.x0 < p.x0) ? q.x0 : p.x0;
        r.y0 = (q.y0 < p.y0) ? q.y0 : p.y0;
        r.x1 = (q.x1 > p.x1) ? q.x1 : p.x1;
        r.y1 = (q.y1 > p.y1) ? q.y1 : p.y1;
        return r;
    endfunction

endpackage

FILE: src/rcm_if.sv
interface rcm_in_if;
    import rcm_pkg::*;
    logic valid;
    logic ready;
    logic has_rect;
    logic [13:0] pos_x;
    logic [13:0] pos_y;
    logic [13:0] size_w;
    logic [13:0] size_h;
    logic last_in;
    modport source (output valid, has_rect, pos_x, pos_y, size_w, size_h, last_in,
                    input ready);
    modport sink (input valid, has_rect, pos_x, pos_y, size_w, size_h, last_in,
                  output ready);
endinterface

interface rcm_out_if;
    import rcm_pkg::*;
    logic valid;
    logic ready;
    coord_t box_x0;
    coord_t box_y0;
    coord_t box_x1;
    coord_t box_y1;
    logic no_box;
    logic last_out;
    modport source (output valid, box_x0, box_y0, box_x1, box_y1, no_box, last_out,
                    input ready);
    modport sink (input valid, box_x0, box_y0, box_x1, box_y1, no_box, last_out,
                  output ready);
endinterface

FILE: src/rcm_cell.sv
// One slot of the box list. A cell loads, unions, or takes its right
// neighbor's box when the list is compacted.
module rcm_cell
    import rcm_pkg::*;
(
    input  logic clk,
    input  logic load,
    input  box_t load_box,
    input  logic merge,
    input  box_t merge_box,
    input  logic shift,
    input  box_t right_box,
    output box_t box
);
    box_t box_reg;
    box_t box_next;

    always_comb
    begin
        box_next = box_reg;
        if (load)
            box_next = load_box;
        else if (merge)
            box_next = box_union(box_reg, merge_box);
        else if (shift)
            box_next = right_box;
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

    assign box = box_reg;
endmodule

FILE: src/rect_cluster_merge_unit.sv
// A request is taken only in idle. Placement scans one stored box per cycle, and
// each merge sweep walks the pairs of stored boxes; sweeps repeat until one makes
// no merge. On a last request the list is emitted at one box per cycle while
// ready is high. Throughput: one request at a time; the input waits until the
// previous request is placed, merged and, if last, emitted. Reset clears count
// and control and sets the merge distance and list limit to their defaults.
module rect_cluster_merge_unit
    import rcm_pkg::*;
#(
    parameter int MAX_BOXES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    rcm_in_if.sink   in_ch,
    rcm_out_if.source out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CntW = $clog2(MAX_BOXES + 1);

    logic [DistW-1:0] dist_reg;
    logic [LimW-1:0]  limit_reg;
    state_t state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [IdxW-1:0] a_reg, a_next, b_reg, b_next;
    logic changed_reg, changed_next;
    logic last_reg, last_next;
    box_t nb_reg, nb_next;
    box_t cells [MAX_BOXES];

    logic [MAX_BOXES-1:0] ld, mg, sh;
    box_t ld_box, mg_box;

    genvar g;
    generate
        for (g = 0; g < MAX_BOXES; g++)
        begin : g_cell
            box_t rb;
            if (g == MAX_BOXES - 1) begin : g_end
                assign rb = cells[g];
            end else begin : g_mid
                assign rb = cells[g+1];
            end
            rcm_cell u_cell (
                .clk(clk), .load(ld[g]), .load_box(ld_box), .merge(mg[g]),
                .merge_box(mg_box), .shift(sh[g]), .right_box(rb), .box(cells[g])
            );
        end
    endgenerate

    // Effective limit clamped to [1, MAX_BOXES].
    logic [CntW:0] eff_limit;
    always_comb
    begin
        if (limit_reg == '0)
            eff_limit = (CntW+1)'(1);
        else if (32'(limit_reg) > 32'(MAX_BOXES))
            eff_limit = (CntW+1)'(MAX_BOXES);
        else
            eff_limit = (CntW+1)'(limit_reg);
    end

    box_t cell_a, cell_b;
    assign cell_a = cells[a_reg];
    assign cell_b = cells[b_reg];

    logic near_new, near_ab;
    assign near_new = boxes_near(nb_reg, cell_a, dist_reg);
    assign near_ab  = boxes_near(cell_a, cell_b, dist_reg);

    logic full;
    assign full = {1'b0, count_reg} >= eff_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg  <= DistW'(50);
            limit_reg <= LimW'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MERGE_DISTANCE: dist_reg  <= cfg_data;
                REG_LIST_LIMIT:     limit_reg <= cfg_data[LimW-1:0];
                default: ;
            endcase
        end
    end

    // Next state and datapath control.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        changed_next = changed_reg;
        last_next    = last_reg;
        nb_next      = nb_reg;
        ld = '0; mg = '0; sh = '0;
        ld_box = nb_reg;
        mg_box = nb_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    nb_next.x0 = {1'b0, in_ch.pos_x};
                    nb_next.y0 = {1'b0, in_ch.pos_y};
                    nb_next.x1 = {1'b0, in_ch.pos_x} + {1'b0, in_ch.size_w};
                    nb_next.y1 = {1'b0, in_ch.pos_y} + {1'b0, in_ch.size_h};
                    last_next  = in_ch.last_in;
                    a_next     = '0;
                    if (in_ch.has_rect)
                        state_next = ST_PLACE;
                    else if (in_ch.last_in)
                    begin
                        state_next = ST_PASS;
                        changed_next = 1'b0;
                        b_next = IdxW'(count_reg - 1'b1);
                    end
                end
            end
            ST_PLACE:
            begin
                if ({1'b0, a_reg} < CntW'(count_reg))
                begin
                    if (full || near_new)
                    begin
                        mg[a_reg] = 1'b1;
                        state_next = last_reg ? ST_PASS : ST_IDLE;
                        a_next = '0;
                        b_next = IdxW'(count_reg - 1'b1);
                        changed_next = 1'b0;
                    end
                    else
                        a_next = a_reg + 1'b1;
                end
                else
                begin
                    if (count_reg < CntW'(MAX_BOXES))
                    begin
                        ld[IdxW'(count_reg)] = 1'b1;
                        count_next = count_reg + 1'b1;
                        state_next = ST_PASS;
                        b_next = IdxW'(count_reg);
                    end
                    else
                        state_next = last_reg ? ST_PASS : ST_IDLE;
                    if (count_reg >= CntW'(MAX_BOXES))
                        b_next = IdxW'(count_reg - 1'b1);
                    a_next = '0;
                    changed_next = 1'b0;
                end
            end
            ST_PASS:
            begin
                // One (a, b) pair per cycle; a shifting merge also compacts.
                if ({1'b0, a_reg} + 1'b1 >= CntW'(count_reg) || count_reg == '0)
                begin
                    if (changed_reg)
                    begin
                        changed_next = 1'b0;
                        a_next = '0;
                        b_next = IdxW'(count_reg - 1'b1);
                    end
                    else if (last_reg)
                    begin
                        state_next = ST_EMIT;
                        a_next = '0;
                    end
                    else
                        state_next = ST_IDLE;
                end
                else if (b_reg > a_reg)
                begin
                    if (near_ab)
                    begin
                        mg_box = cell_b;
                        mg[a_reg] = 1'b1;
                        for (int k = 0; k < MAX_BOXES; k++)
                            if (IdxW'(k) >= b_reg)
                                sh[k] = 1'b1;
                        count_next = count_reg - 1'b1;
                        changed_next = 1'b1;
                    end
                    b_next = b_reg - 1'b1;
                end
                else
                begin
                    a_next = a_reg + 1'b1;
                    b_next = IdxW'(count_reg - 1'b1);
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    if (count_reg == '0 || {1'b0, a_reg} + 1'b1 >= CntW'(count_reg))
                    begin
                        state_next = ST_IDLE;
                        count_next = '0;
                    end
                    else
                        a_next = a_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            changed_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            changed_reg <= changed_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_reg <= nb_next;
    end

    // Outputs.
    always_comb
    begin
        in_ch.ready     = (state_reg == ST_IDLE);
        out_ch.valid    = (state_reg == ST_EMIT);
        out_ch.no_box   = (count_reg == '0);
        out_ch.last_out = (count_reg == '0) || ({1'b0, a_reg} + 1'b1 >= CntW'(count_reg));
        out_ch.box_x0   = out_ch.no_box ? '0 : cell_a.x0;
        out_ch.box_y0   = out_ch.no_box ? '0 : cell_a.y0;
        out_ch.box_x1   = out_ch.no_box ? '0 : cell_a.x1;
        out_ch.box_y1   = out_ch.no_box ? '0 : cell_a.y1;
    end
endmodule

FILE: src/rcm_checker.sv
module rcm_checker
    import rcm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic no_box,
    input logic last_out
);
    // Intake and emission never overlap.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("intake during emission");

    a_nobox: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_box |-> last_out) else $error("empty set not last");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind rect_cluster_merge_unit rcm_checker u_rcm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .no_box(out_ch.no_box),
    .last_out(out_ch.last_out)
);
